>>> rtl/sha0h_pkg.sv
// Shared types, constants and round functions for the SHA-0 message hasher.
`timescale 1ns / 1ps

package sha0h_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned LenW       = 61;

  localparam logic [31:0] PadMark   = 32'h8000_0000;
  localparam logic [3:0]  LenSlot   = 4'd14;
  localparam logic [3:0]  LastSlot  = 4'd15;
  localparam logic [6:0]  LastRound = 7'd79;
  localparam logic [2:0]  LastIdx   = 3'd4;
  localparam logic [2:0]  FullBytes = 3'd4;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
  } sha0h_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha0h_out_t;

  // Classified item handed from the front to the compression engine.
  typedef struct packed {
    logic [31:0] word;     // first block word to store (already masked and padded)
    logic [2:0]  len_inc;  // message bytes this item adds
    logic        first;
    logic        last;
    logic        mark;     // pad byte still owed as a separate word
  } sha0h_cmd_t;

  function automatic logic [31:0] init_word(input logic [2:0] k);
    logic [31:0] v;
    case (k)
      3'd0:    v = 32'h6745_2301;
      3'd1:    v = 32'hefcd_ab89;
      3'd2:    v = 32'h98ba_dcfe;
      3'd3:    v = 32'h1032_5476;
      default: v = 32'hc3d2_e1f0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [1:0] grp);
    logic [31:0] v;
    case (grp)
      2'd0:    v = 32'h5a82_7999;
      2'd1:    v = 32'h6ed9_eba1;
      2'd2:    v = 32'h8f1b_bcdc;
      default: v = 32'hca62_c1d6;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] v;
    case (grp)
      2'd0:    v = (x & y) | (~x & z);
      2'd2:    v = (x & y) ^ (x & z) ^ (y & z);
      default: v = x ^ y ^ z;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/sha0h_queue.sv
// Small register FIFO between the classifier and the compression engine.
`timescale 1ns / 1ps

module sha0h_queue
  import sha0h_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  sha0h_cmd_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output sha0h_cmd_t rd_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sha0h_cmd_t          store [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                push;
  logic                pop;

  assign wr_ready = count < CntW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = store[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/sha0h_front.sv
// Input side: classifies each message item and queues it for the engine.
`timescale 1ns / 1ps

module sha0h_front
  import sha0h_pkg::*;
#(
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  sha0h_in_t  msg,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output sha0h_cmd_t cmd
);

  sha0h_cmd_t cls;

  // Short last word: keep the leading bytes and place the pad byte right after them.
  always_comb begin
    cls.first   = msg.first_word;
    cls.last    = msg.last_word;
    cls.word    = msg.msg_word;
    cls.len_inc = FullBytes;
    cls.mark    = 1'b0;
    if (msg.last_word) begin
      case (msg.valid_bytes)
        3'd0: begin
          cls.word    = PadMark;
          cls.len_inc = 3'd0;
        end
        3'd1: begin
          cls.word    = {msg.msg_word[31:24], 24'h80_0000};
          cls.len_inc = 3'd1;
        end
        3'd2: begin
          cls.word    = {msg.msg_word[31:16], 16'h8000};
          cls.len_inc = 3'd2;
        end
        3'd3: begin
          cls.word    = {msg.msg_word[31:8], 8'h80};
          cls.len_inc = 3'd3;
        end
        default: begin
          // four or more: whole word, pad goes into the next slot
          cls.mark = 1'b1;
        end
      endcase
    end
  end

  sha0h_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(msg_valid),
    .wr_ready(msg_ready),
    .wr_data (cls),
    .rd_valid(cmd_valid),
    .rd_ready(cmd_ready),
    .rd_data (cmd)
  );

endmodule

>>> rtl/sha0h_core.sv
// Compression engine: block buffer, 80-round loop, padding tail and digest output.
`timescale 1ns / 1ps

module sha0h_core
  import sha0h_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  sha0h_cmd_t cmd,
  output logic       digest_valid,
  input  logic       digest_ready,
  output sha0h_out_t digest
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_ROUNDS,
    S_FOLD,
    S_EMIT
  } state_t;

  // What the padding tail still has to do after the current put.
  typedef enum logic [2:0] {
    TL_RET,
    TL_MARK,
    TL_FILL,
    TL_LENL,
    TL_EMIT
  } tail_t;

  state_t          state;
  tail_t           tail;
  tail_t           tail_next;
  logic [3:0]      pos;
  logic [3:0]      eff_pos;
  logic [LenW-1:0] len;
  logic [6:0]      rnd;
  logic [2:0]      idx;
  logic [31:0]     chain [5];
  logic [31:0]     sr [16];
  logic [31:0]     va, vb, vc, vd, ve;

  logic            put_en;
  logic [31:0]     put_data;
  logic            sr_shift;
  logic [31:0]     sr_in;
  logic [1:0]      grp;
  logic [31:0]     w_r;
  logic [31:0]     t_sum;

  assign eff_pos = (state == S_IDLE && cmd.first) ? 4'd0 : pos;

  always_comb begin
    cmd_ready = 1'b0;
    put_en    = 1'b0;
    put_data  = '0;
    tail_next = tail;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          put_en    = 1'b1;
          put_data  = cmd.word;
          if (!cmd.last) begin
            tail_next = TL_RET;
          end else if (cmd.mark) begin
            tail_next = TL_MARK;
          end else begin
            tail_next = TL_FILL;
          end
        end
      end
      S_NEXT: begin
        case (tail)
          TL_MARK: begin
            put_en    = 1'b1;
            put_data  = PadMark;
            tail_next = TL_FILL;
          end
          TL_FILL: begin
            put_en = 1'b1;
            if (pos == LenSlot) begin
              put_data  = len[LenW-1:LenW-32];
              tail_next = TL_LENL;
            end
          end
          TL_LENL: begin
            put_en    = 1'b1;
            put_data  = {len[LenW-33:0], 3'b000};
            tail_next = TL_EMIT;
          end
          default: begin
            put_en = 1'b0;
          end
        endcase
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // Schedule taps: sr[0] is w[t-16], sr[2] w[t-14], sr[8] w[t-8], sr[13] w[t-3].
  always_comb begin
    if (rnd < 7'd20) begin
      grp = 2'd0;
    end else if (rnd < 7'd40) begin
      grp = 2'd1;
    end else if (rnd < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
    w_r   = (rnd < 7'd16) ? sr[0] : (sr[13] ^ sr[8] ^ sr[2] ^ sr[0]);
    t_sum = {va[26:0], va[31:27]} + round_f(grp, vb, vc, vd) + ve + round_k(grp) + w_r;
  end

  assign sr_shift = put_en || (state == S_ROUNDS);
  assign sr_in    = (state == S_ROUNDS) ? w_r : put_data;

  always_ff @(posedge clk) begin
    if (sr_shift) begin
      for (int i = 0; i < 15; i++) begin
        sr[i] <= sr[i + 1];
      end
      sr[15] <= sr_in;
    end
    if (put_en && eff_pos == LastSlot) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (state == S_ROUNDS) begin
      va <= t_sum;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tail         <= TL_RET;
      pos          <= '0;
      len          <= '0;
      rnd          <= '0;
      idx          <= '0;
      digest_valid <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        chain[k] <= init_word(3'(k));
      end
    end else begin
      if (state == S_IDLE && cmd_valid) begin
        if (cmd.first) begin
          for (int k = 0; k < 5; k++) begin
            chain[k] <= init_word(3'(k));
          end
          len <= LenW'(cmd.len_inc);
        end else begin
          len <= len + LenW'(cmd.len_inc);
        end
      end
      if (put_en) begin
        pos  <= eff_pos + 1'b1;
        tail <= tail_next;
        if (eff_pos == LastSlot) begin
          rnd   <= '0;
          state <= S_ROUNDS;
        end else if (tail_next == TL_RET) begin
          state <= S_IDLE;
        end else begin
          state <= S_NEXT;
        end
      end else begin
        case (state)
          S_NEXT: begin
            if (tail == TL_EMIT) begin
              idx          <= '0;
              digest_valid <= 1'b1;
              state        <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
          S_ROUNDS: begin
            rnd <= rnd + 1'b1;
            if (rnd == LastRound) begin
              state <= S_FOLD;
            end
          end
          S_FOLD: begin
            chain[0] <= chain[0] + va;
            chain[1] <= chain[1] + vb;
            chain[2] <= chain[2] + vc;
            chain[3] <= chain[3] + vd;
            chain[4] <= chain[4] + ve;
            state    <= (tail == TL_RET) ? S_IDLE : S_NEXT;
          end
          S_EMIT: begin
            if (digest_ready) begin
              if (idx == LastIdx) begin
                // message done: back to a fresh start
                digest_valid <= 1'b0;
                for (int k = 0; k < 5; k++) begin
                  chain[k] <= init_word(3'(k));
                end
                len   <= '0;
                pos   <= '0;
                tail  <= TL_RET;
                state <= S_IDLE;
              end else begin
                // rotate so the next digest word sits in chain[0]
                for (int k = 0; k < 4; k++) begin
                  chain[k] <= chain[k + 1];
                end
                chain[4] <= chain[0];
                idx      <= idx + 1'b1;
              end
            end
          end
          default: begin
            state <= state;
          end
        endcase
      end
    end
  end

  assign digest.digest_word  = chain[0];
  assign digest.digest_index = idx;
  assign digest.digest_last  = idx == LastIdx;

`ifndef SYNTH
  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> state == S_EMIT)
    else $error("digest valid outside emit");

  a_fold_at_block_start: assert property (@(posedge clk) disable iff (rst)
    state == S_FOLD |-> pos == 4'd0)
    else $error("fold with block position not at zero");

  a_rounds_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_ROUNDS) |-> rnd == 7'd0)
    else $error("round loop entered mid-count");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUNDS && rnd == LastRound) |=> state == S_FOLD)
    else $error("round loop did not end after last round");

  a_digest_restart: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && idx == LastIdx) |=> (!digest_valid && pos == 4'd0))
    else $error("state not restarted after final digest word");
`endif

endmodule

>>> rtl/sha0_message_hasher.sv
// Top level of the SHA-0 message hasher: classifier front, queue and compression engine.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload      Direction
// msg       msg_valid / msg_ready     sha0h_in_t   in   (one message word per item)
// digest    digest_valid / digest_ready sha0h_out_t out (five items per message)
//
// A plain word goes straight into the block buffer; every 16th word also starts the
// 80 rounds and the fold of that block.
// A last word adds the pad words, one or two more compressions, then
// five digest items, one per cycle while digest_ready is high.
// msg_ready drops only when the front queue is full; it keeps filling during rounds.
// Synchronous active-high rst restores the initial chain, zero length, block slot zero.

module sha0_message_hasher
  import sha0h_pkg::*;
#(
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  sha0h_in_t  msg,
  output logic       digest_valid,
  input  logic       digest_ready,
  output sha0h_out_t digest
);

  sha0h_cmd_t cmd;
  logic       cmd_valid;
  logic       cmd_ready;

  // Front: masks short final words, places the pad byte, queues the item.
  sha0h_front #(
    .QDEPTH(QDEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .msg      (msg),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // Back: block buffer, rounds, padding tail and registered digest output.
  sha0h_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest      (digest)
  );

endmodule
